// File: hw/rtl/obf_pkg.sv
// shared types, codes and step tables for the outline flattener
package obf_pkg;

    localparam int MAX_STEPS = 16;
    localparam int MIN_STEPS = 3;
    localparam int STEP_W    = 5;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;

    localparam logic [2:0] ACT_MOVE   = 3'd0;
    localparam logic [2:0] ACT_LINE   = 3'd1;
    localparam logic [2:0] ACT_QUAD   = 3'd2;
    localparam logic [2:0] ACT_CUBIC  = 3'd3;
    localparam logic [2:0] ACT_FINISH = 3'd4;

    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_STEPS = 1'b1;

    localparam logic KIND_POINT  = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_LINE  = 2'd1,
        OP_QUAD  = 2'd2,
        OP_CUBIC = 2'd3
    } op_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] ctrl1_x;
        logic signed [15:0] ctrl1_y;
        logic signed [15:0] ctrl2_x;
        logic signed [15:0] ctrl2_y;
        logic signed [15:0] to_x;
        logic signed [15:0] to_y;
    } item_t;

    typedef struct packed {
        logic               kind;
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic               keep;
        logic               last;
    } result_t;

    // one decoded command handed from front to back
    typedef struct packed {
        logic               marker;
        logic               keep;
        op_t                op;
        logic [STEP_W-1:0]  steps;
        logic signed [15:0] p0_x;
        logic signed [15:0] p0_y;
        logic signed [15:0] c1_x;
        logic signed [15:0] c1_y;
        logic signed [15:0] c2_x;
        logic signed [15:0] c2_y;
        logic signed [15:0] to_x;
        logic signed [15:0] to_y;
    } cmd_t;

    // floor(65536 / steps)
    function automatic logic [16:0] step_quot(input logic [STEP_W-1:0] s);
        logic [16:0] q;
        case (s)
            5'd3:    q = 17'd21845;
            5'd4:    q = 17'd16384;
            5'd5:    q = 17'd13107;
            5'd6:    q = 17'd10922;
            5'd7:    q = 17'd9362;
            5'd8:    q = 17'd8192;
            5'd9:    q = 17'd7281;
            5'd10:   q = 17'd6553;
            5'd11:   q = 17'd5957;
            5'd12:   q = 17'd5461;
            5'd13:   q = 17'd5041;
            5'd14:   q = 17'd4681;
            5'd15:   q = 17'd4369;
            5'd16:   q = 17'd4096;
            default: q = 17'd0;
        endcase
        return q;
    endfunction

    // 65536 mod steps
    function automatic logic [STEP_W-1:0] step_rem(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] r;
        case (s)
            5'd3:    r = 5'd1;
            5'd5:    r = 5'd1;
            5'd6:    r = 5'd4;
            5'd7:    r = 5'd2;
            5'd9:    r = 5'd7;
            5'd10:   r = 5'd6;
            5'd11:   r = 5'd9;
            5'd12:   r = 5'd4;
            5'd13:   r = 5'd3;
            5'd14:   r = 5'd2;
            5'd15:   r = 5'd1;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/obf_queue.sv
// short command queue between front and back
module obf_queue
    import obf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/obf_front.sv
// command intake: contour state tracking and decode into queue entries
module obf_front
    import obf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    input  logic [STEP_W-1:0] steps_cfg,
    input  logic              q_full,
    output logic              push,
    output cmd_t              push_cmd
);

    logic signed [15:0] cur_x_reg, cur_x_next;
    logic signed [15:0] cur_y_reg, cur_y_next;
    logic               open_reg, open_next;
    logic [1:0]         count_reg, count_next;
    logic               take;
    logic [STEP_W-1:0]  steps_eff;
    logic [STEP_W:0]    count_sum;

    assign item_ready = !q_full;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        if (steps_cfg < STEP_W'(MIN_STEPS))
            steps_eff = STEP_W'(MIN_STEPS);
        else if (steps_cfg > STEP_W'(MAX_STEPS))
            steps_eff = STEP_W'(MAX_STEPS);
        else
            steps_eff = steps_cfg;
    end

    always_comb
    begin
        push_cmd.marker = 1'b0;
        push_cmd.keep   = (count_reg == 2'd3);
        push_cmd.op     = OP_NONE;
        push_cmd.steps  = steps_eff;
        push_cmd.p0_x   = cur_x_reg;
        push_cmd.p0_y   = cur_y_reg;
        push_cmd.c1_x   = item.ctrl1_x;
        push_cmd.c1_y   = item.ctrl1_y;
        push_cmd.c2_x   = item.ctrl2_x;
        push_cmd.c2_y   = item.ctrl2_y;
        push_cmd.to_x   = item.to_x;
        push_cmd.to_y   = item.to_y;
        push            = 1'b0;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        open_next       = open_reg;
        count_next      = count_reg;
        count_sum       = '0;
        case (item.action)
            ACT_MOVE:
            begin
                push_cmd.marker = 1'b1;
                push_cmd.op     = OP_LINE;
                push            = take;
                cur_x_next      = item.to_x;
                cur_y_next      = item.to_y;
                open_next       = 1'b1;
                count_next      = 2'd1;
            end
            ACT_FINISH:
            begin
                push_cmd.marker = 1'b1;
                push            = take;
                cur_x_next      = '0;
                cur_y_next      = '0;
                open_next       = 1'b0;
                count_next      = 2'd0;
            end
            ACT_LINE:
            begin
                push_cmd.op = OP_LINE;
                push        = take;
                cur_x_next  = item.to_x;
                cur_y_next  = item.to_y;
                open_next   = 1'b1;
                count_next  = (count_reg == 2'd3) ? 2'd3 : count_reg + 2'd1;
            end
            ACT_QUAD, ACT_CUBIC:
            begin
                push_cmd.op = (item.action == ACT_QUAD) ? OP_QUAD : OP_CUBIC;
                push        = take && open_reg;
                if (open_reg)
                begin
                    cur_x_next = item.to_x;
                    cur_y_next = item.to_y;
                    count_sum  = (STEP_W+1)'(count_reg) + (STEP_W+1)'(steps_eff);
                    count_next = (count_sum >= (STEP_W+1)'(3)) ? 2'd3 : count_sum[1:0];
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            open_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (take)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            open_reg  <= open_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/obf_back.sv
// point generation: step sequencer and bernstein/scale pipeline
module obf_back
    import obf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_pop,
    input  cmd_t        cmd,
    input  logic [31:0] scale,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    typedef struct packed {
        logic kind;
        logic keep;
        logic last;
    } tag_t;

    // sequencer
    logic              busy_reg;
    logic              mark_reg;
    cmd_t              cur_reg;
    logic [STEP_W-1:0] k_reg;
    logic [STEP_W-1:0] r_reg;
    logic [16:0]       q_reg;
    logic              adv;
    logic [STEP_W-1:0] rn, rn_wrap;
    logic              wrap;
    logic [16:0]       qn;
    logic [STEP_W-1:0] k_inc;
    logic              iss_cubic;
    logic [16:0]       iss_t;
    tag_t              iss_tag;

    assign adv     = !result_valid || result_ready;
    assign cmd_pop = adv && !busy_reg && cmd_valid;
    assign k_inc   = k_reg + 1'b1;

    always_comb
    begin
        rn        = r_reg + step_rem(cur_reg.steps);
        wrap      = (rn >= cur_reg.steps);
        rn_wrap   = wrap ? rn - cur_reg.steps : rn;
        qn        = q_reg + step_quot(cur_reg.steps) + 17'(wrap);
        iss_cubic = !mark_reg && (cur_reg.op == OP_CUBIC);
        if (mark_reg)
            iss_t = '0;
        else if (cur_reg.op == OP_LINE)
            iss_t = 17'h10000;
        else
            iss_t = qn;
        iss_tag.kind = mark_reg ? KIND_MARKER : KIND_POINT;
        iss_tag.keep = mark_reg && cur_reg.keep;
        if (mark_reg)
            iss_tag.last = (cur_reg.op == OP_NONE);
        else
            iss_tag.last = (cur_reg.op == OP_LINE) || (k_inc == cur_reg.steps);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mark_reg <= 1'b0;
        end
        else if (cmd_pop)
        begin
            busy_reg <= 1'b1;
            mark_reg <= cmd.marker;
        end
        else if (adv && busy_reg)
        begin
            mark_reg <= 1'b0;
            if (iss_tag.last)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
            k_reg   <= '0;
            q_reg   <= '0;
            r_reg   <= cmd.steps >> 1;
        end
        else if (adv && busy_reg && !mark_reg)
        begin
            k_reg <= k_inc;
            q_reg <= qn;
            r_reg <= rn_wrap;
        end
    end

    // pipeline
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    tag_t        g1_reg, g2_reg, g3_reg, g4_reg, g5_reg, g6_reg;
    logic        cub1_reg, cub2_reg;
    cmd_t        c1_reg, c2_reg, c3_reg;
    logic [16:0] t1_reg, u1_reg, t2_reg, u2_reg;
    logic [33:0] uu_reg, ut_reg, tt_reg;
    logic [48:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic signed [65:0] px0_reg, px1_reg, px2_reg, px3_reg;
    logic signed [65:0] py0_reg, py1_reg, py2_reg, py3_reg;
    logic signed [31:0] qx_reg, qy_reg;
    logic signed [64:0] sx_reg, sy_reg;
    result_t     res_reg;
    logic        res_valid_reg;

    logic [50:0] uuu, uut, utt, ttt;
    logic [48:0] w0_next, w1_next, w2_next, w3_next;
    logic signed [65:0] sum_x, sum_y, rnd_x, rnd_y;
    logic signed [64:0] fin_x, fin_y;

    always_comb
    begin
        uuu = 51'(uu_reg) * 51'(u2_reg);
        uut = 51'(uu_reg) * 51'(t2_reg);
        utt = 51'(ut_reg) * 51'(t2_reg);
        ttt = 51'(tt_reg) * 51'(t2_reg);
        if (cub2_reg)
        begin
            w0_next = uuu[48:0];
            w1_next = uut[48:0] + {uut[47:0], 1'b0};
            w2_next = utt[48:0] + {utt[47:0], 1'b0};
            w3_next = ttt[48:0];
        end
        else
        begin
            w0_next = {uu_reg[32:0], 16'd0};
            w1_next = {ut_reg[31:0], 17'd0};
            w2_next = '0;
            w3_next = {tt_reg[32:0], 16'd0};
        end
        sum_x = px0_reg + px1_reg + px2_reg + px3_reg;
        sum_y = py0_reg + py1_reg + py2_reg + py3_reg;
        rnd_x = sum_x + 66'sh80000000;
        rnd_y = sum_y + 66'sh80000000;
        fin_x = sx_reg + 65'sh8000;
        fin_y = sy_reg + 65'sh8000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= busy_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            res_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // t and u
            g1_reg   <= iss_tag;
            cub1_reg <= iss_cubic;
            c1_reg   <= cur_reg;
            t1_reg   <= iss_t;
            u1_reg   <= 17'h10000 - iss_t;
            // second-order terms
            g2_reg   <= g1_reg;
            cub2_reg <= cub1_reg;
            c2_reg   <= c1_reg;
            t2_reg   <= t1_reg;
            u2_reg   <= u1_reg;
            uu_reg   <= u1_reg * u1_reg;
            ut_reg   <= u1_reg * t1_reg;
            tt_reg   <= t1_reg * t1_reg;
            // Q1.48 weights
            g3_reg   <= g2_reg;
            c3_reg   <= c2_reg;
            w0_reg   <= w0_next;
            w1_reg   <= w1_next;
            w2_reg   <= w2_next;
            w3_reg   <= w3_next;
            // weighted coordinates
            g4_reg   <= g3_reg;
            px0_reg  <= $signed({1'b0, w0_reg}) * c3_reg.p0_x;
            px1_reg  <= $signed({1'b0, w1_reg}) * c3_reg.c1_x;
            px2_reg  <= $signed({1'b0, w2_reg}) * c3_reg.c2_x;
            px3_reg  <= $signed({1'b0, w3_reg}) * c3_reg.to_x;
            py0_reg  <= $signed({1'b0, w0_reg}) * c3_reg.p0_y;
            py1_reg  <= $signed({1'b0, w1_reg}) * c3_reg.c1_y;
            py2_reg  <= $signed({1'b0, w2_reg}) * c3_reg.c2_y;
            py3_reg  <= $signed({1'b0, w3_reg}) * c3_reg.to_y;
            // round to Q.16 font units
            g5_reg   <= g4_reg;
            qx_reg   <= rnd_x[63:32];
            qy_reg   <= rnd_y[63:32];
            // apply scale
            g6_reg   <= g5_reg;
            sx_reg   <= qx_reg * $signed({1'b0, scale});
            sy_reg   <= qy_reg * $signed({1'b0, scale});
            // round to Q24.24
            res_reg.kind <= g6_reg.kind;
            res_reg.keep <= g6_reg.keep;
            res_reg.last <= g6_reg.last;
            res_reg.x    <= (g6_reg.kind == KIND_MARKER) ? '0 : fin_x[63:16];
            res_reg.y    <= (g6_reg.kind == KIND_MARKER) ? '0 : fin_y[63:16];
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// File: hw/rtl/outline_bezier_flattener.sv
// top level of the outline flattener: config registers, front, queue, back
// Takes one outline command per item (move, line, quadratic, cubic, finish)
// in signed 16-bit font units and returns contour points scaled to signed
// Q24.24, plus an end-of-contour marker ahead of every move and finish. The
// front accepts one item per cycle while the four-entry command queue has
// room; items that give no result (curve with no current point, unknown
// action) are absorbed there. The back loads a command and then gives one
// result per cycle unless stalled by result_ready: a line gives 1, a move 2,
// a finish 1 and a curve curve_steps results (3 to 16). The point pipeline
// registers t/u, weight products, coordinate products, rounding, scale
// multiply and final rounding in that order.
// The whole pipeline stalls while a result waits on result_ready.
// Configuration is written through cfg_valid/cfg_index/cfg_data, always ready:
// index 0 is scale_factor (unsigned Q8.24), index 1 curve_steps, clamped to
// 3..16 when used. Write configuration only while the block is idle.
module outline_bezier_flattener
    import obf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0]       scale_reg;
    logic [STEP_W-1:0] steps_reg;
    logic              q_full, q_empty, q_push, q_pop;
    cmd_t              q_in, q_head;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 32'd16777216;
            steps_reg <= 5'd6;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCALE: scale_reg <= cfg_data;
                CFG_STEPS: steps_reg <= cfg_data[STEP_W-1:0];
                default:   scale_reg <= scale_reg;
            endcase
        end
    end

    // intake and contour tracking
    obf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .steps_cfg  (steps_reg),
        .q_full     (q_full),
        .push       (q_push),
        .push_cmd   (q_in)
    );

    // decoupling queue
    obf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // point generation
    obf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!q_empty),
        .cmd_pop      (q_pop),
        .cmd          (q_head),
        .scale        (scale_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: hw/rtl/obf_checker.sv
// port-level checks for the outline flattener, bound to the top level
module obf_checker
    import obf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // a waiting result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result dropped or changed while stalled");

    // markers carry no coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_MARKER |-> result.x == '0 && result.y == '0)
        else $error("marker with nonzero coordinates");

    // keep only on markers
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_POINT |-> !result.keep)
        else $error("keep set on a point");

    // a marker that closes a contour is never the last result of a move
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.kind == KIND_MARKER && !result.last
        |=> !result_valid || result.kind == KIND_POINT)
        else $error("marker followed by marker within one command");

endmodule

bind outline_bezier_flattener obf_checker u_obf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// File: sim/tb_outline_bezier_flattener.sv
// testbench for the outline flattener: directed and random commands against a predictor
`timescale 1ns / 100ps

module tb_outline_bezier_flattener;
    import obf_pkg::*;

    // expected contour results in order, checked field by field
    class point_board;
        result_t pending[$];
        int errors;

        function void note(result_t r);
            pending = {pending, r};
        endfunction

        function void check(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result kind=%0d x=%0d y=%0d", got.kind, got.x, got.y);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind expected %0d actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.x !== want.x)
            begin
                $error("x expected %0d actual %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y)
            begin
                $error("y expected %0d actual %0d", want.y, got.y);
                errors++;
            end
            if (got.keep !== want.keep)
            begin
                $error("keep expected %0d actual %0d", want.keep, got.keep);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    point_board board;

    // predictor state, mirrors the block
    logic [31:0]        pr_scale;
    logic [4:0]         pr_steps;
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;
    logic               pen_down;
    int                 pen_count;

    // idle percentages and the long receiver hold-off
    int send_idle;
    int recv_idle;
    int hold_cycles;

    outline_bezier_flattener uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // round-to-nearest (half up) arithmetic shift
    function automatic longint round_sh(longint s, int sh);
        return (s + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // Q.16 font units to Q24.24 output
    function automatic logic [47:0] to_out(longint p16);
        longint prod;
        prod = p16 * longint'({32'd0, pr_scale});
        return 48'(round_sh(prod, 16));
    endfunction

    function automatic result_t mk_point(longint px16, longint py16);
        result_t r;
        r.kind = KIND_POINT;
        r.x    = to_out(px16);
        r.y    = to_out(py16);
        r.keep = 1'b0;
        r.last = 1'b0;
        return r;
    endfunction

    // works out the results of one accepted command and updates pen state
    task automatic flatten_command(item_t it);
        result_t outs[$];
        result_t r;
        longint t, u, sx, sy, w0, w1, w2, w3;
        int n;
        if (it.action == ACT_MOVE || it.action == ACT_FINISH)
        begin
            r = '0;
            r.kind = KIND_MARKER;
            r.keep = (pen_count >= 3);
            outs = {outs, r};
            if (it.action == ACT_MOVE)
            begin
                outs = {outs, mk_point(longint'(it.to_x) * 65536,
                                       longint'(it.to_y) * 65536)};
                pen_x = it.to_x;
                pen_y = it.to_y;
                pen_down = 1'b1;
                pen_count = 1;
            end
            else
            begin
                pen_x = '0;
                pen_y = '0;
                pen_down = 1'b0;
                pen_count = 0;
            end
        end
        else if (it.action == ACT_LINE)
        begin
            outs = {outs, mk_point(longint'(it.to_x) * 65536, longint'(it.to_y) * 65536)};
            pen_x = it.to_x;
            pen_y = it.to_y;
            pen_down = 1'b1;
            pen_count = (pen_count + 1 > 3) ? 3 : pen_count + 1;
        end
        else if ((it.action == ACT_QUAD || it.action == ACT_CUBIC) && pen_down)
        begin
            n = pr_steps;
            if (n < MIN_STEPS)
                n = MIN_STEPS;
            if (n > MAX_STEPS)
                n = MAX_STEPS;
            for (int k = 1; k <= n; k++)
            begin
                t = (k * 65536 + n / 2) / n;
                u = 65536 - t;
                if (it.action == ACT_QUAD)
                begin
                    w0 = u * u;
                    w1 = 2 * u * t;
                    w2 = t * t;
                    sx = w0 * pen_x + w1 * it.ctrl1_x + w2 * it.to_x;
                    sy = w0 * pen_y + w1 * it.ctrl1_y + w2 * it.to_y;
                    outs = {outs, mk_point(round_sh(sx, 16), round_sh(sy, 16))};
                end
                else
                begin
                    w0 = u * u * u;
                    w1 = 3 * u * u * t;
                    w2 = 3 * u * t * t;
                    w3 = t * t * t;
                    sx = w0 * pen_x + w1 * it.ctrl1_x + w2 * it.ctrl2_x + w3 * it.to_x;
                    sy = w0 * pen_y + w1 * it.ctrl1_y + w2 * it.ctrl2_y + w3 * it.to_y;
                    outs = {outs, mk_point(round_sh(sx, 32), round_sh(sy, 32))};
                end
            end
            pen_x = it.to_x;
            pen_y = it.to_y;
            pen_count = (pen_count + n > 3) ? 3 : pen_count + n;
        end
        if (outs.size() > 0)
        begin
            outs[outs.size() - 1].last = 1'b1;
            foreach (outs[i])
                board.note(outs[i]);
        end
    endtask

    // offers one command, random idle before it, and waits for acceptance
    // valid is dropped by the next call or by the drain
    task automatic send_command(item_t it);
        if ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        flatten_command(it);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SCALE)
            pr_scale = val;
        else
            pr_steps = val[4:0];
        @(posedge clk);
    endtask

    // waits for every expected result, then lets absorbed commands drain
    task automatic drain_results();
        item_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic item_t rand_command(logic [2:0] act);
        item_t it;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        it.action = act;
        // mostly small coordinates, sometimes full range
        if ($urandom_range(3) != 0)
        begin
            it.ctrl1_x = $signed(16'($urandom_range(2000))) - 16'sd1000;
            it.ctrl1_y = $signed(16'($urandom_range(2000))) - 16'sd1000;
            it.to_x = $signed(16'($urandom_range(2000))) - 16'sd1000;
            it.to_y = $signed(16'($urandom_range(2000))) - 16'sd1000;
        end
        return it;
    endfunction

    function automatic item_t edge_command(logic [2:0] act, logic signed [15:0] v);
        item_t it;
        it.action = act;
        it.ctrl1_x = v;
        it.ctrl1_y = -v;
        it.ctrl2_x = ~v;
        it.ctrl2_y = v;
        it.to_x = -v;
        it.to_y = v;
        return it;
    endfunction

    // one well-formed contour with random segments
    task automatic send_contour();
        int segs;
        segs = $urandom_range(1, 5);
        send_command(rand_command(ACT_MOVE));
        repeat (segs)
            send_command(rand_command(3'($urandom_range(ACT_LINE, ACT_CUBIC))));
    endtask

    // receiver: random stall, with a long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle);
        if (rst_n && result_valid && result_ready)
            board.check(result);
    end

    initial
    begin
        #20ms;
        $display("outline_bezier_flattener test failed");
        $finish;
    end

    initial
    begin
        int sent;
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SCALE;
        cfg_data = '0;
        send_idle = 0;
        recv_idle = 0;
        hold_cycles = 0;
        board = new();
        pr_scale = 32'd16777216;
        pr_steps = 5'd6;
        pen_x = '0;
        pen_y = '0;
        pen_down = 1'b0;
        pen_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: curves with no pen, unknown actions, field extremes
        send_command(edge_command(ACT_QUAD, 16'sh7fff));
        send_command(edge_command(ACT_CUBIC, 16'sh7fff));
        send_command(edge_command(3'd5, 16'sh1234));
        send_command(edge_command(3'd7, -16'sh1));
        send_command(edge_command(ACT_FINISH, 16'sh0));
        send_command(edge_command(ACT_LINE, -16'sh8000));
        send_command(edge_command(ACT_CUBIC, 16'sh7fff));
        send_command(edge_command(ACT_QUAD, -16'sh8000));
        send_command(edge_command(ACT_MOVE, 16'sh7fff));
        send_command(edge_command(ACT_CUBIC, -16'sh8000));
        send_command(edge_command(ACT_LINE, 16'sh7fff));
        send_command(edge_command(3'd6, 16'sh0));
        send_command(edge_command(ACT_MOVE, -16'sh8000));
        send_command(edge_command(ACT_MOVE, 16'sh1));
        send_command(edge_command(ACT_FINISH, 16'sh0));
        send_command(edge_command(ACT_FINISH, 16'sh0));
        drain_results();

        // several register settings, extremes included; steps out of range clamp
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_SCALE, 32'hffffffff); write_reg(CFG_STEPS, 32'd16); end
                1: begin write_reg(CFG_SCALE, 32'd0); write_reg(CFG_STEPS, 32'd3); end
                2: begin write_reg(CFG_SCALE, $urandom); write_reg(CFG_STEPS, 32'd31); end
                3: begin write_reg(CFG_SCALE, 32'd1); write_reg(CFG_STEPS, 32'd0); end
                4: begin write_reg(CFG_SCALE, $urandom); write_reg(CFG_STEPS, $urandom); end
                default: begin write_reg(CFG_SCALE, 32'h01800000); write_reg(CFG_STEPS, 32'd7); end
            endcase
            send_idle = (phase < 2) ? 28 : (phase < 4) ? 67 : 0;
            recv_idle = (phase < 2) ? 67 : (phase < 4) ? 28 : 0;
            if (phase == 4)
                hold_cycles = 300;
            sent = 0;
            while (sent < 42)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_command(rand_command(3'($urandom_range(7))));
                    sent++;
                end
                else
                begin
                    send_contour();
                    sent += 4;
                end
                // sender pause until everything has come out
                if (phase == 5 && sent > 20 && sent < 25)
                begin
                    item_valid <= 1'b0;
                    while (board.pending.size() != 0)
                        @(posedge clk);
                end
            end
            drain_results();
        end

        if (board.errors == 0)
            $display("outline_bezier_flattener test passed");
        else
            $display("outline_bezier_flattener test failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/obf_pkg.sv
hw/rtl/obf_queue.sv
hw/rtl/obf_front.sv
hw/rtl/obf_back.sv
hw/rtl/outline_bezier_flattener.sv
hw/rtl/obf_checker.sv
sim/tb_outline_bezier_flattener.sv
